// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

// ===== rtl/core/fpalu_pkg.sv =====
package fpalu_pkg;

    localparam int DataWidth      = 32;
    localparam int DefaultFracBits = 8;
    localparam int KindWidth      = 4;

    typedef logic [KindWidth-1:0] kind_t;

    localparam kind_t KindAdd     = 4'd0;
    localparam kind_t KindSub     = 4'd1;
    localparam kind_t KindMul     = 4'd2;
    localparam kind_t KindDiv     = 4'd3;
    localparam kind_t KindInc     = 4'd4;
    localparam kind_t KindDec     = 4'd5;
    localparam kind_t KindMin     = 4'd6;
    localparam kind_t KindMax     = 4'd7;
    localparam kind_t KindFromInt = 4'd8;
    localparam kind_t KindToInt   = 4'd9;

    typedef struct packed {
        logic a_greater;
        logic a_less;
        logic a_equal;
    } cmp_flags_t;

    typedef struct packed {
        kind_t      kind;
        logic       neg;
        logic       b_zero;
        cmp_flags_t cmp;
    } op_ctrl_t;

endpackage

// ===== rtl/core/fpalu_if.sv =====
interface fpalu_in_if;
    import fpalu_pkg::*;
    logic                        valid;
    logic                        ready;
    kind_t                       kind;
    logic signed [DataWidth-1:0] operand_a;
    logic signed [DataWidth-1:0] operand_b;

    modport source (output valid, kind, operand_a, operand_b, input ready);
    modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface fpalu_out_if;
    import fpalu_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [DataWidth-1:0] result_value;
    logic                        a_greater;
    logic                        a_less;
    logic                        a_equal;
    logic                        divide_by_zero;
    logic                        saturated;

    modport source (output valid, result_value, a_greater, a_less, a_equal,
                    divide_by_zero, saturated, input ready);
    modport sink   (input valid, result_value, a_greater, a_less, a_equal,
                    divide_by_zero, saturated, output ready);
endinterface

// ===== rtl/core/fixed_point_alu.sv =====
// Fixed-point ALU on signed 32-bit raw values with FracBits fraction bits.
// Channels: "in" carries kind, operand_a, operand_b; "out" carries
// result_value, compare flags, divide_by_zero and saturated.
// One word is accepted per cycle when the pipeline can advance.
// The divider sets the depth and resolves one quotient bit per stage;
// every kind travels the same depth so results leave in order.
// Throughput is one word per cycle while the receiver does not stall.
// The multiplier result is registered and carried alongside the divider.
// Reset clears all valid bits; no word is in flight after reset.
// When the receiver stalls with a word on the output, the whole pipeline
// freezes; in.ready drops only then, so nothing is lost or repeated.
// Empty stages do not close up during a stall; every stage holds.
// Unused kinds return zero with the compare flags still valid.
// Divide by zero returns zero with divide_by_zero set.
module fixed_point_alu #(
    parameter int FracBits = fpalu_pkg::DefaultFracBits
) (
    input logic  clk,
    input logic  rst_n,
    fpalu_in_if.sink    in,
    fpalu_out_if.source out
);
    import fpalu_pkg::*;
    `include "assert_macros.svh"

    logic       en;
    logic       core_valid;
    cmp_flags_t cmp;

    assign en       = !out.valid || out.ready;
    assign in.ready = en;

    fpalu_core #(.FracBits(FracBits)) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (in.valid),
        .kind           (in.kind),
        .operand_a      (in.operand_a),
        .operand_b      (in.operand_b),
        .out_valid      (core_valid),
        .result_value   (out.result_value),
        .cmp            (cmp),
        .divide_by_zero (out.divide_by_zero),
        .saturated      (out.saturated)
    );

    assign out.valid     = core_valid;
    assign out.a_greater = cmp.a_greater;
    assign out.a_less    = cmp.a_less;
    assign out.a_equal   = cmp.a_equal;

    `ASSERT_ALWAYS(a_cmp_onehot, clk, rst_n,
        !out.valid || $onehot({out.a_greater, out.a_less, out.a_equal}), "compare flags")
    `ASSERT_ALWAYS(a_flags_excl, clk, rst_n,
        !out.valid || !(out.divide_by_zero && out.saturated), "dz and sat both set")
    `ASSERT_IMPL(a_dz_zero, clk, rst_n, out.valid && out.divide_by_zero,
        out.result_value == '0, "dz with nonzero result")
    `ASSERT_IMPL(a_stall_hold, clk, rst_n, out.valid && !out.ready,
        ##1 (out.valid && $stable(out.result_value)), "stalled word changed")
endmodule

// ===== rtl/core/fpalu_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
// Quotient of (2*num + den) / (2*den), numerator and denominator unsigned.
module fpalu_div #(
    parameter int NumWidth = 40,
    parameter int DenWidth = 32
) (
    input  logic                clk,
    input  logic                en,
    input  logic [NumWidth-1:0] num,
    input  logic [DenWidth-1:0] den,
    output logic [NumWidth-1:0] quot
);
    localparam int NW = NumWidth + 2;
    localparam int DW = DenWidth + 1;
    localparam int RW = DW + 1;

    logic [NW-1:0] n_reg   [NW+1];
    logic [DW-1:0] d_reg   [NW+1];
    logic [RW-1:0] r_reg   [NW+1];
    logic [NW-1:0] q_reg   [NW+1];

    always_comb
    begin
        n_reg[0] = {1'b0, num, 1'b0} + NW'(den);
        d_reg[0] = {den, 1'b0};
        r_reg[0] = '0;
        q_reg[0] = '0;
    end

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [RW-1:0] trial;
        logic          ge;
        always_comb
        begin
            trial = {r_reg[i][RW-2:0], n_reg[i][NW-1-i]};
            ge    = trial >= RW'(d_reg[i]);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i+1] <= n_reg[i];
                d_reg[i+1] <= d_reg[i];
                r_reg[i+1] <= ge ? trial - RW'(d_reg[i]) : trial;
                q_reg[i+1] <= {q_reg[i][NW-2:0], ge};
            end
        end
    end

    assign quot = q_reg[NW][NumWidth-1:0];
endmodule

// ===== rtl/core/fpalu_core.sv =====
// Operand decode, multiplier and adder paths; divider alongside.
module fpalu_core #(
    parameter int FracBits = fpalu_pkg::DefaultFracBits
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  fpalu_pkg::kind_t                      kind,
    input  logic signed [fpalu_pkg::DataWidth-1:0] operand_a,
    input  logic signed [fpalu_pkg::DataWidth-1:0] operand_b,
    output logic                                  out_valid,
    output logic signed [fpalu_pkg::DataWidth-1:0] result_value,
    output fpalu_pkg::cmp_flags_t                 cmp,
    output logic                                  divide_by_zero,
    output logic                                  saturated
);
    import fpalu_pkg::*;

    localparam int W    = DataWidth;
    localparam int NumW = W + FracBits;
    localparam int Lat  = NumW + 2;
    localparam int PW   = 2 * W;
    localparam logic signed [W+1:0] MaxPos = (W+2)'(2**(W-1) - 1);
    localparam logic signed [W+1:0] MinNeg = -(W+2)'(2**(W-1));

    // Stage 1: magnitudes, simple results, compare.
    logic [W-1:0]          mag_a, mag_b;
    logic signed [W+1:0]   simple_next;
    logic                  simple_sat_next;
    op_ctrl_t              ctrl_next;
    logic signed [W+FracBits:0] shifted;
    logic signed [W+1:0]   raw;

    always_comb
    begin
        mag_a = operand_a[W-1] ? W'(-operand_a) : W'(operand_a);
        mag_b = operand_b[W-1] ? W'(-operand_b) : W'(operand_b);
        ctrl_next.kind   = kind;
        ctrl_next.neg    = operand_a[W-1] ^ operand_b[W-1];
        ctrl_next.b_zero = operand_b == '0;
        ctrl_next.cmp.a_greater = operand_a > operand_b;
        ctrl_next.cmp.a_less    = operand_a < operand_b;
        ctrl_next.cmp.a_equal   = operand_a == operand_b;
        shifted = (W+FracBits+1)'(operand_a) <<< FracBits;
        raw = '0;
        case (kind)
            KindAdd: raw = (W+2)'(operand_a) + (W+2)'(operand_b);
            KindSub: raw = (W+2)'(operand_a) - (W+2)'(operand_b);
            KindInc: raw = (W+2)'(operand_a) + (W+2)'(1);
            KindDec: raw = (W+2)'(operand_a) - (W+2)'(1);
            KindMin: raw = (operand_a <= operand_b) ? (W+2)'(operand_a) : (W+2)'(operand_b);
            KindMax: raw = (operand_a > operand_b) ? (W+2)'(operand_a) : (W+2)'(operand_b);
            KindToInt: raw = (W+2)'(operand_a >>> FracBits);
            default: raw = '0;
        endcase
        simple_sat_next = 1'b0;
        simple_next = raw;
        if (kind == KindFromInt)
        begin
            if (shifted > (W+FracBits+1)'(MaxPos))
            begin
                simple_next = MaxPos;
                simple_sat_next = 1'b1;
            end
            else if (shifted < (W+FracBits+1)'(MinNeg))
            begin
                simple_next = MinNeg;
                simple_sat_next = 1'b1;
            end
            else
                simple_next = (W+2)'(shifted);
        end
        else if (raw > MaxPos)
        begin
            simple_next = MaxPos;
            simple_sat_next = 1'b1;
        end
        else if (raw < MinNeg)
        begin
            simple_next = MinNeg;
            simple_sat_next = 1'b1;
        end
    end

    // Delay line carrying control, simple result and product across divider depth.
    logic                v_reg      [Lat];
    op_ctrl_t            ctrl_reg   [Lat];
    logic signed [W+1:0] simple_reg [Lat];
    logic                ssat_reg   [Lat];
    logic [PW-1:0]       prod_reg   [Lat];
    logic [W-1:0]        ma_reg, mb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Lat; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < Lat; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_reg[0]   <= ctrl_next;
            simple_reg[0] <= simple_next;
            ssat_reg[0]   <= simple_sat_next;
            ma_reg        <= mag_a;
            mb_reg        <= mag_b;
            prod_reg[0]   <= '0;
            prod_reg[1]   <= PW'(ma_reg) * PW'(mb_reg);
            for (int i = 1; i < Lat; i++)
            begin
                ctrl_reg[i]   <= ctrl_reg[i-1];
                simple_reg[i] <= simple_reg[i-1];
                ssat_reg[i]   <= ssat_reg[i-1];
            end
            for (int i = 2; i < Lat; i++)
                prod_reg[i] <= prod_reg[i-1];
        end
    end

    logic [NumW-1:0] quot;
    fpalu_div #(.NumWidth(NumW), .DenWidth(W)) u_div (
        .clk  (clk),
        .en   (en),
        .num  ({mag_a, FracBits'(0)}),
        .den  (mag_b),
        .quot (quot)
    );

    // Final stage: rounding, sign, saturation and divide by zero of mul/div.
    op_ctrl_t           c;
    logic [PW-1:0]      pr;
    logic [PW:0]        mag_r;
    logic signed [PW+1:0] sgn;
    logic signed [W-1:0] res_next;
    logic               sat_next;
    logic               dz_next;

    always_comb
    begin
        c     = ctrl_reg[Lat-1];
        pr    = prod_reg[Lat-1];
        mag_r = '0;
        if (c.kind == KindMul)
            mag_r = ((PW+1)'(pr) + (PW+1)'(1 << (FracBits-1))) >> FracBits;
        else
            mag_r = (PW+1)'(quot);
        sgn = c.neg ? -(PW+2)'(mag_r) : (PW+2)'(mag_r);
        res_next = W'(simple_reg[Lat-1]);
        sat_next = ssat_reg[Lat-1];
        dz_next  = 1'b0;
        if (c.kind == KindMul || c.kind == KindDiv)
        begin
            sat_next = 1'b0;
            if (c.kind == KindDiv && c.b_zero)
            begin
                res_next = '0;
                dz_next  = 1'b1;
            end
            else if (sgn > (PW+2)'(MaxPos))
            begin
                res_next = W'(MaxPos);
                sat_next = 1'b1;
            end
            else if (sgn < (PW+2)'(MinNeg))
            begin
                res_next = W'(MinNeg);
                sat_next = 1'b1;
            end
            else
                res_next = W'(sgn);
        end
    end

    logic out_v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= v_reg[Lat-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_value   <= res_next;
            cmp            <= c.cmp;
            divide_by_zero <= dz_next;
            saturated      <= sat_next;
        end
    end

    assign out_valid = out_v_reg;
endmodule
